// ----- rtl/bfws_pkg.sv -----
// Shared types and constants for the box filter window sum block.
`default_nettype none
package bfws_pkg;

    localparam int MAX_RADIUS = 32;
    localparam int LINE_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int SAMPLE_W   = 8;
    localparam int SUM_W      = 15;
    localparam int RADIUS_W   = 6;
    localparam int COUNT_W    = $clog2(LINE_DEPTH + 1);
    localparam int APB_AW     = 3;

    // register byte addresses, word index taken from paddr[2]
    localparam logic REG_WINDOW_RADIUS = 1'b0;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [RADIUS_W-1:0] t_radius;
    typedef logic [COUNT_W-1:0]  t_count;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

    // control from the sequencer to the delay line
    typedef struct packed {
        logic    shift;
        t_sample sample;
        t_count  tap_idx;
    } t_line_ctrl;

endpackage
`default_nettype wire

// ----- rtl/bfws_cell.sv -----
// One stage of the sample delay line.
`default_nettype none
module bfws_cell (
    input  wire                     i_clk,
    input  wire                     i_shift,
    input  wire  bfws_pkg::t_sample i_d,
    output bfws_pkg::t_sample       o_q
);
    import bfws_pkg::*;

    t_sample r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// ----- rtl/bfws_line.sv -----
// Delay line built as a chain of cells, with a selectable tap.
`default_nettype none
module bfws_line (
    input  wire                        i_clk,
    input  wire  bfws_pkg::t_line_ctrl i_ctrl,
    output bfws_pkg::t_sample          o_tap
);
    import bfws_pkg::*;

    t_sample w_q [LINE_DEPTH];

    // cell k holds the sample written k+1 requests ago
    for (genvar k = 0; k < LINE_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            bfws_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctrl.shift),
                .i_d     (i_ctrl.sample),
                .o_q     (w_q[k])
            );
        end else begin : g_body
            bfws_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctrl.shift),
                .i_d     (w_q[k-1]),
                .o_q     (w_q[k])
            );
        end
    end

    always_comb begin
        o_tap = '0;
        for (int k = 0; k < LINE_DEPTH; k++) begin
            if (i_ctrl.tap_idx == COUNT_W'(k)) begin
                o_tap = w_q[k];
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/box_filter_window_sum.sv -----
// Top level: clamped-border moving window sum over framed 8-bit samples.
//
// Input stream s_*: one sample per request, s_tlast on the last sample of a
// frame. Output stream m_*: one window sum per position, m_tlast on the final
// result of the frame. Radius r is set over the APB port (reset value 1,
// values above 32 act as 32); a write outside a flush restarts the frame state.
// Samples are taken one per cycle while no flush is under way and the output
// register is free or being drained. The result for position p is registered
// into the output register as sample p+r is taken.
// After the last sample of a frame, up to r flush results follow at one per
// cycle while the output register is free or being drained; the input is held
// off meanwhile. The flush removes at most one old sample per cycle through
// the delay line tap. Reset clears the frame state and the output valid flag;
// delay line contents are never read before they are written within the
// current frame. When m_tready is low the result waits in the output register
// and no new sample is taken until it is free.
`default_nettype none
module box_filter_window_sum (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // APB configuration
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [bfws_pkg::APB_AW-1:0] paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // sample stream
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [7:0]                  s_tdata,   // [7:0] sample
    input  wire                         s_tlast,   // frame_end
    // result stream
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [15:0]                 m_tdata,   // [14:0] window_sum, [15] zero
    output logic                        m_tlast    // last_of_frame
);
    import bfws_pkg::*;

    t_state     r_state, n_state;
    t_radius    r_radius;
    t_sum       r_sum, n_sum;
    t_count     r_seen, n_seen;
    t_count     r_cnt, n_cnt;
    t_radius    r_left, n_left;
    logic       r_out_valid, n_out_valid;
    t_sum       r_out_sum, n_out_sum;
    logic       r_out_last, n_out_last;

    t_line_ctrl w_line;
    t_sample    w_tap;

    logic       w_cfg_wr;
    logic       w_slot_free;
    logic       w_accept;
    t_radius    w_rad;
    t_count     w_win;
    t_count     w_seen_new;
    t_radius    w_left_dec;
    t_count     w_want_raw;
    t_count     w_want;
    logic       w_drop;

    assign pready   = 1'b1;
    // writes to unmapped addresses leave the frame state alone
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == REG_WINDOW_RADIUS);
    assign prdata   = (paddr[2] == REG_WINDOW_RADIUS) ? {26'd0, r_radius} : 32'd0;

    assign w_rad = (r_radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : r_radius;
    assign w_win = {w_rad, 1'b1};

    assign w_slot_free = !r_out_valid || m_tready;
    assign s_tready    = (r_state == ST_RUN) && w_slot_free;
    assign w_accept    = s_tvalid && s_tready;

    assign w_seen_new = (r_seen >= w_win) ? r_seen : r_seen + 1'b1;

    // flush bookkeeping: window of position j ends at min(j+r, held-1)
    assign w_left_dec = r_left - 1'b1;
    assign w_want_raw = COUNT_W'(w_left_dec) + COUNT_W'(w_rad) + 1'b1;
    assign w_want     = (w_want_raw > r_seen) ? r_seen : w_want_raw;
    assign w_drop     = r_cnt > w_want;

    always_comb begin
        w_line.shift   = w_accept;
        w_line.sample  = s_tdata;
        w_line.tap_idx = (r_state == ST_FLUSH) ? r_cnt - 1'b1 : {w_rad, 1'b0};
    end

    bfws_line u_line (
        .i_clk  (i_clk),
        .i_ctrl (w_line),
        .o_tap  (w_tap)
    );

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_seen      = r_seen;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_out_valid = r_out_valid && !m_tready;
        n_out_sum   = r_out_sum;
        n_out_last  = r_out_last;
        case (r_state)
            ST_RUN: begin
                if (w_cfg_wr) begin
                    n_sum  = '0;
                    n_seen = '0;
                end else if (w_accept) begin
                    n_sum  = r_sum - ((r_seen >= w_win) ? SUM_W'(w_tap) : '0)
                           + SUM_W'(s_tdata);
                    n_seen = w_seen_new;
                    if (w_seen_new >= COUNT_W'(w_rad) + 1'b1) begin
                        n_out_valid = 1'b1;
                        n_out_sum   = n_sum;
                        n_out_last  = s_tlast && (w_rad == '0);
                    end
                    if (s_tlast) begin
                        if (w_rad == '0) begin
                            n_sum  = '0;
                            n_seen = '0;
                        end else begin
                            // flush count min(held, r) is at least one here
                            n_left  = (w_seen_new < COUNT_W'(w_rad)) ?
                                      RADIUS_W'(w_seen_new) : w_rad;
                            n_cnt   = w_seen_new;
                            n_state = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = w_drop ? r_sum - SUM_W'(w_tap) : r_sum;
                    n_out_last  = (w_left_dec == '0);
                    n_sum       = n_out_sum;
                    n_cnt       = w_drop ? r_cnt - 1'b1 : r_cnt;
                    n_left      = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_sum   = '0;
                        n_seen  = '0;
                        n_state = ST_RUN;
                    end
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_radius    <= RADIUS_W'(1);
            r_sum       <= '0;
            r_seen      <= '0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_seen      <= n_seen;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && paddr[2] == REG_WINDOW_RADIUS) begin
                r_radius <= pwdata[RADIUS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sum  <= n_out_sum;
        r_out_last <= n_out_last;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out_sum};
    assign m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_no_input_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> !s_tready)
        else $error("sample taken during flush");

    a_seen_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= w_win)
        else $error("sample count beyond window length");

    a_flush_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (r_cnt <= r_seen && r_left != '0))
        else $error("flush counters out of range");

    a_zero_radius_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_tlast && w_rad == '0) |=> (m_tvalid && m_tlast))
        else $error("missing last result for zero radius");
`endif

endmodule
`default_nettype wire
